// ----- hw/rtl/c2d_pkg.sv -----
// c2d_pkg: shared constants and types for the COO-to-dense matrix converter.
// No dependencies; imported by c2d_scan and coo_triplets_to_dense_matrix.
package c2d_pkg;

	localparam int IDX_BITS       = 3;   // width of row / column coordinates
	localparam int OUT_VAL_BITS   = 16;  // width of entry and element values
	localparam int MAX_ROWS_DEF   = 8;
	localparam int MAX_COLS_DEF   = 8;
	localparam int VALUE_BITS_DEF = 16;

	// one read issued by the scan sequencer
	typedef struct packed {
		logic                rd_en;
		logic [IDX_BITS-1:0] row;
		logic [IDX_BITS-1:0] col;
		logic                last;  // final element of the matrix
	} c2d_rd_t;

endpackage

// ----- hw/rtl/c2d_ram.sv -----
// c2d_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module c2d_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/c2d_scan.sv -----
// c2d_scan: row-major readout sequencer with a row counter and a column counter.
// Depends on c2d_pkg.
module c2d_scan #(
	parameter int MAX_ROWS = c2d_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = c2d_pkg::MAX_COLS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [c2d_pkg::IDX_BITS-1:0]  row_max,
	input  logic [c2d_pkg::IDX_BITS-1:0]  col_max,
	input  logic                          adv,
	output logic                          busy,
	output c2d_pkg::c2d_rd_t              rd,
	output logic [((((MAX_ROWS < 8) ? MAX_ROWS : 8) * ((MAX_COLS < 8) ? MAX_COLS : 8)) > 1 ?
	              $clog2(((MAX_ROWS < 8) ? MAX_ROWS : 8) * ((MAX_COLS < 8) ? MAX_COLS : 8))
	              : 1) - 1:0]           rd_addr
);
	import c2d_pkg::*;

	localparam int IDX_SPAN = 2 ** IDX_BITS;
	localparam int ER    = (MAX_ROWS < IDX_SPAN) ? MAX_ROWS : IDX_SPAN;
	localparam int EC    = (MAX_COLS < IDX_SPAN) ? MAX_COLS : IDX_SPAN;
	localparam int DEPTH = ER * EC;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                busy_q;
	logic [IDX_BITS-1:0] row_q, col_q, rmax_q, cmax_q;
	logic [AW-1:0]       base_q;
	logic                col_end, row_end, step;

	assign col_end = (col_q == cmax_q);
	assign row_end = (row_q == rmax_q);
	assign step    = busy_q && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			row_q  <= '0;
			col_q  <= '0;
			base_q <= '0;
			rmax_q <= '0;
			cmax_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			row_q  <= '0;
			col_q  <= '0;
			base_q <= '0;
			rmax_q <= row_max;
			cmax_q <= col_max;
		end else if (step) begin
			if (col_end) begin
				col_q <= '0;
				if (row_end) begin
					busy_q <= 1'b0;
				end else begin
					row_q  <= row_q + 1'b1;
					base_q <= base_q + AW'(EC);
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	assign busy     = busy_q;
	assign rd.rd_en = step;
	assign rd.row   = row_q;
	assign rd.col   = col_q;
	assign rd.last  = col_end && row_end;
	assign rd_addr  = base_q + AW'(col_q);

	a_scan_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (row_q <= rmax_q) && (col_q <= cmax_q))
		else $error("scan counter past matrix bounds");

	a_scan_done: assert property (@(posedge clk) disable iff (!arst_n)
		(step && rd.last && !start) |=> !busy_q)
		else $error("scan still busy after final element");

	a_scan_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !adv && !start) |=> $stable(row_q) && $stable(col_q))
		else $error("scan moved without advance");

endmodule

// ----- hw/rtl/coo_triplets_to_dense_matrix.sv -----
// coo_triplets_to_dense_matrix: top level of the COO triplet to dense matrix converter.
// Depends on c2d_pkg, c2d_ram and c2d_scan.
//
// Takes one (row, column, value) triplet per word and writes it into a dense store
// that reads as zero until written; a later triplet at the same position overwrites
// the earlier one. Triplets with a coordinate at or beyond MAX_ROWS / MAX_COLS are
// dropped, but their last_entry flag still counts. On the word flagged last_entry,
// the block emits the (largest row + 1) x (largest column + 1) matrix in row-major
// order, out_last on the final element, and then starts over with an empty store.
// An empty matrix comes out as a single zero. Rate: triplets without last_entry are
// taken one per cycle while in_stall is low. A last triplet starts a readout of R x C
// elements at one element per cycle while out_stall stays low, the pace of the store's
// single read port; the first element passes the scan, the read stage and the output
// register before out_valid rises. in_stall stays high until the last of the R x C
// reads issues, which out_stall can delay by holding the readout. The output register
// lets the next matrix start loading while the tail drains.
// Per-entry valid flops make the store read as zero, so there is no clearing pass.
module coo_triplets_to_dense_matrix #(
	parameter int MAX_ROWS   = c2d_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS   = c2d_pkg::MAX_COLS_DEF,
	parameter int VALUE_BITS = c2d_pkg::VALUE_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// triplet input
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic        [c2d_pkg::IDX_BITS-1:0]     row_index,
	input  logic        [c2d_pkg::IDX_BITS-1:0]     col_index,
	input  logic signed [c2d_pkg::OUT_VAL_BITS-1:0] entry_value,
	input  logic                                    last_entry,
	// dense element output
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic        [c2d_pkg::IDX_BITS-1:0]     out_row,
	output logic        [c2d_pkg::IDX_BITS-1:0]     out_col,
	output logic signed [c2d_pkg::OUT_VAL_BITS-1:0] out_value,
	output logic                                    out_last
);
	import c2d_pkg::*;

	// only coordinates the 3-bit fields can reach need storage
	localparam int IDX_SPAN = 2 ** IDX_BITS;
	localparam int ER    = (MAX_ROWS < IDX_SPAN) ? MAX_ROWS : IDX_SPAN;
	localparam int EC    = (MAX_COLS < IDX_SPAN) ? MAX_COLS : IDX_SPAN;
	localparam int DEPTH = ER * EC;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	// stored width: 16-bit signed values are cut to VALUE_BITS bits when that is narrower
	localparam int SB    = (VALUE_BITS < OUT_VAL_BITS) ? VALUE_BITS : OUT_VAL_BITS;

	logic                in_acc, in_rng, wr_en, start;
	logic [AW-1:0]       wr_addr, rd_addr;
	logic [IDX_BITS-1:0] lrow_q, lcol_q, nrow, ncol;
	logic [DEPTH-1:0]    vld_q;
	logic                scan_busy, out_free, mv, adv;
	c2d_rd_t             rd;
	logic [SB-1:0]       rdata;

	logic                rd_vld_s1, rd_set_s1, rd_last_s1;
	logic [IDX_BITS-1:0] rd_row_s1, rd_col_s1;

	logic                    out_valid_q, out_last_q;
	logic [IDX_BITS-1:0]     out_row_q, out_col_q;
	logic [OUT_VAL_BITS-1:0] out_value_q;

	// input side: busy only while the scan is issuing reads
	assign in_stall = scan_busy;
	assign in_acc   = in_valid && !scan_busy;
	assign in_rng   = (int'(row_index) < MAX_ROWS) && (int'(col_index) < MAX_COLS);
	assign wr_en    = in_acc && in_rng;
	assign wr_addr  = AW'(int'(row_index) * EC + int'(col_index));
	assign start    = in_acc && last_entry;

	// running maxima including the current triplet
	assign nrow = (wr_en && (row_index > lrow_q)) ? row_index : lrow_q;
	assign ncol = (wr_en && (col_index > lcol_q)) ? col_index : lcol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lrow_q <= '0;
			lcol_q <= '0;
		end else if (start) begin
			lrow_q <= '0;
			lcol_q <= '0;
		end else if (in_acc) begin
			lrow_q <= nrow;
			lcol_q <= ncol;
		end
	end

	// per-entry written flags; dropped once the final read of a matrix issues
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (rd.rd_en && rd.last) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	c2d_ram #(
		.WIDTH (SB),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (entry_value[SB-1:0]),
		.re    (rd.rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// readout: scan issues a read whenever the read stage is free or moving on
	assign out_free = !out_valid_q || !out_stall;
	assign mv       = rd_vld_s1 && out_free;
	assign adv      = !rd_vld_s1 || out_free;

	c2d_scan #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.row_max (nrow),
		.col_max (ncol),
		.adv     (adv),
		.busy    (scan_busy),
		.rd      (rd),
		.rd_addr (rd_addr)
	);

	// read stage: RAM data lands here; RAM data holds since no read issues while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else if (rd.rd_en) begin
			rd_vld_s1 <= 1'b1;
		end else if (mv) begin
			rd_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.rd_en) begin
			rd_row_s1  <= rd.row;
			rd_col_s1  <= rd.col;
			rd_last_s1 <= rd.last;
			rd_set_s1  <= vld_q[rd_addr];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (mv) begin
			out_valid_q <= 1'b1;
		end else if (out_free) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mv) begin
			out_row_q   <= rd_row_s1;
			out_col_q   <= rd_col_s1;
			out_last_q  <= rd_last_s1;
			out_value_q <= rd_set_s1 ? OUT_VAL_BITS'(rdata) : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;

	a_no_read_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_vld_s1 && out_valid_q && out_stall) |-> !rd.rd_en)
		else $error("read issued over a held read stage");

	a_last_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && last_entry) |=> scan_busy)
		else $error("last triplet did not start readout");

	a_maxima_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && last_entry) |=> (lrow_q == '0) && (lcol_q == '0))
		else $error("maxima not cleared after last triplet");

endmodule
